// File: rtl/cascaded_time_window_average_top_defines.svh
// Assertion macros shared by the cascaded time window average RTL.
// Assumes the including module has clk_i and rst_ni in scope.
`ifndef CASCADED_TIME_WINDOW_AVERAGE_TOP_DEFINES_SVH
`define CASCADED_TIME_WINDOW_AVERAGE_TOP_DEFINES_SVH

// Check a condition on every clock edge outside reset
`define CTWA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define CTWA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/ctwa_pkg.sv
// Package for the cascaded time window average: sizes, level codes and
// ring address helpers. No dependencies.
`timescale 1ns / 1ps

package ctwa_pkg;

  localparam int SHORT_DEPTH = 64;
  localparam int DAY_DEPTH   = 32;
  localparam int MAX_DEPTH   = (SHORT_DEPTH > DAY_DEPTH) ? SHORT_DEPTH : DAY_DEPTH;
  localparam int PTR_W       = $clog2(MAX_DEPTH);
  localparam int FILL_W      = PTR_W + 1;
  // sum of up to MAX_DEPTH signed 32-bit values
  localparam int SUM_W       = PTR_W + 33;
  localparam int MEM_DEPTH   = 2 * SHORT_DEPTH + DAY_DEPTH;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int DIVC_W      = $clog2(SUM_W + 1);

  typedef logic [1:0] lvl_t;
  localparam lvl_t LVL_MIN  = 2'd0;
  localparam lvl_t LVL_HOUR = 2'd1;
  localparam lvl_t LVL_DAY  = 2'd2;

  localparam logic [31:0] WIN_MIN  = 32'd59;
  localparam logic [31:0] WIN_HOUR = 32'd3599;
  localparam logic [31:0] WIN_DAY  = 32'd86399;
  localparam logic [31:0] GAP_MIN  = 32'd60;
  localparam logic [31:0] GAP_HOUR = 32'd3600;

  // divider request and response
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [FILL_W-1:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  function automatic logic [FILL_W-1:0] depth_of(lvl_t l);
    return (l == LVL_DAY) ? FILL_W'(DAY_DEPTH) : FILL_W'(SHORT_DEPTH);
  endfunction

  function automatic logic [31:0] window_of(lvl_t l);
    logic [31:0] w;
    case (l)
      LVL_MIN:  w = WIN_MIN;
      LVL_HOUR: w = WIN_HOUR;
      default:  w = WIN_DAY;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] gap_of(lvl_t l);
    return (l == LVL_MIN) ? GAP_MIN : GAP_HOUR;
  endfunction

  // (h + k) mod d for h < d and k < d
  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] h,
                                                logic [FILL_W-1:0] k,
                                                logic [FILL_W-1:0] d);
    logic [FILL_W-1:0] s;
    s = {1'b0, h} + k;
    if (s >= d) s = s - d;
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(lvl_t l, logic [PTR_W-1:0] slot);
    logic [ADDR_W-1:0] a;
    case (l)
      LVL_MIN:  a = ADDR_W'(slot);
      LVL_HOUR: a = ADDR_W'(SHORT_DEPTH) + ADDR_W'(slot);
      default:  a = ADDR_W'(2 * SHORT_DEPTH) + ADDR_W'(slot);
    endcase
    return a;
  endfunction

endpackage

// File: rtl/ctwa_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Depends on ctwa_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module ctwa_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctwa_pkg::div_req_t req_i,
  output ctwa_pkg::div_rsp_t rsp_o
);
  import ctwa_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic              zero_q;
  logic [SUM_W-1:0]  mag_q;
  logic [FILL_W-1:0] rem_q;
  logic [FILL_W-1:0] dvs_q;
  logic [DIVC_W-1:0] cnt_q;
  logic [FILL_W:0]   rem_sh;
  logic              bit_ok;
  logic [SUM_W-1:0]  quo_full;

  // shift in the next dividend bit and try a subtract
  assign rem_sh = {rem_q, mag_q[SUM_W-1]};
  assign bit_ok = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == DIVC_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q  <= req_i.dividend[SUM_W-1];
      zero_q <= (req_i.divisor == '0);
      mag_q  <= req_i.dividend[SUM_W-1] ? SUM_W'(-req_i.dividend)
                                        : SUM_W'(req_i.dividend);
      dvs_q  <= req_i.divisor;
      rem_q  <= '0;
      cnt_q  <= DIVC_W'(SUM_W);
    end else if (busy_q) begin
      rem_q  <= bit_ok ? FILL_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[FILL_W-1:0];
      mag_q  <= {mag_q[SUM_W-2:0], bit_ok};
      cnt_q  <= cnt_q - DIVC_W'(1);
    end
  end

  // truncate toward zero: divide magnitudes, then restore the sign
  assign quo_full = neg_q ? (~mag_q + SUM_W'(1)) : mag_q;

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = zero_q ? 32'd0 : quo_full[31:0];

endmodule

// File: rtl/cascaded_time_window_average_top.sv
// Flow: per level, evict expired entries (and the oldest one of a full ring), write
// the new sample and rescan the ring for min and max unless it was empty; a cascaded
// push divides the level sum; then three divisions give the averages.
// Throughput: one request at a time; the next can be taken in the cycle after the
// result is loaded, so an output stall also holds the next request.
// Reset: async, active low; sums, fills and pointers clear, level_count = 1.
`timescale 1ns / 1ps
`include "cascaded_time_window_average_top_defines.svh"

module cascaded_time_window_average_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_wdata_i,     // level_count
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,    // sample_value, sample_time
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // latest_value, window_minimum, window_maximum, minute_avg,
  // hour_avg, day_avg, sample_total
  output logic [223:0] m_axis_tdata
);
  import ctwa_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_COUNT   = 15'b000000000000010,
    S_EV_RD   = 15'b000000000000100,
    S_EV_CHK  = 15'b000000000001000,
    S_FULL_RD = 15'b000000000010000,
    S_FULL_EV = 15'b000000000100000,
    S_WRITE   = 15'b000000001000000,
    S_SCAN    = 15'b000000010000000,
    S_PUSH    = 15'b000000100000000,
    S_FINAL   = 15'b000001000000000,
    S_DIV     = 15'b000010000000000,
    S_RD_MIN  = 15'b000100000000000,
    S_RD_MAX  = 15'b001000000000000,
    S_GET_MAX = 15'b010000000000000,
    S_OUT     = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // ring memory shared by all levels
  logic [63:0]       mem [MEM_DEPTH];
  logic [63:0]       rdata_q;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [63:0]       wdata;
  logic              mem_we;

  // per-level state
  logic signed [SUM_W-1:0] sum_q [3];
  logic [PTR_W-1:0]        head_q [3];
  logic [FILL_W-1:0]       fill_q [3];
  logic [PTR_W-1:0]        min_slot_q [3];
  logic [PTR_W-1:0]        max_slot_q [3];
  logic [31:0]             last_push_q [3];
  logic [31:0]             cnt_q [3];
  logic signed [31:0]      avg_q [3];
  logic [1:0]              level_count_q;

  // current request
  lvl_t               lvl_q;
  lvl_t               levels_q;
  logic signed [31:0] v_q;
  logic signed [31:0] v0_q;
  logic [31:0]        t_q;
  logic [31:0]        oldest_q;
  lvl_t               fidx_q;
  logic               div_push_q;
  logic signed [31:0] min_val_q;
  logic signed [31:0] max_val_q;

  // rescan state
  logic [FILL_W-1:0]  issue_q;
  logic               pend_q;
  logic [PTR_W-1:0]   pend_slot_q;
  logic               first_q;
  logic signed [31:0] bmax_v_q, bmin_v_q;
  logic [PTR_W-1:0]   bmax_s_q, bmin_s_q;

  // output register
  logic               out_valid_q;
  logic [223:0]       out_data_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [FILL_W-1:0]  cur_depth;
  logic [PTR_W-1:0]   cur_head;
  logic [FILL_W-1:0]  cur_fill;
  logic [PTR_W-1:0]   new_slot;
  logic [PTR_W-1:0]   scan_slot;
  logic [31:0]        push_diff;
  logic signed [31:0] rd_val;
  logic [31:0]        rd_time;
  logic               hour_live;
  logic signed [31:0] avg_hour, avg_day;

  assign cur_depth = depth_of(lvl_q);
  assign cur_head  = head_q[lvl_q];
  assign cur_fill  = fill_q[lvl_q];
  assign new_slot  = wrap_add(cur_head, cur_fill, cur_depth);
  assign scan_slot = wrap_add(cur_head, issue_q, cur_depth);
  assign push_diff = t_q - last_push_q[lvl_q];
  assign rd_val    = $signed(rdata_q[31:0]);
  assign rd_time   = rdata_q[63:32];

  ctwa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // memory port: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // sequencer next state, memory addresses and divider request
  always_comb begin
    state_d          = state_q;
    raddr            = mem_addr(lvl_q, cur_head);
    waddr            = mem_addr(lvl_q, new_slot);
    wdata            = {t_q, v_q};
    mem_we           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_q[lvl_q];
    div_req.divisor  = cur_fill;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_COUNT;
      end
      S_COUNT: state_d = S_EV_RD;
      S_EV_RD: begin
        state_d = (cur_fill == '0) ? S_FULL_RD : S_EV_CHK;
      end
      S_EV_CHK: begin
        state_d = (rd_time < oldest_q) ? S_EV_RD : S_FULL_RD;
      end
      S_FULL_RD: begin
        state_d = (cur_fill >= cur_depth) ? S_FULL_EV : S_WRITE;
      end
      S_FULL_EV: state_d = S_WRITE;
      S_WRITE: begin
        mem_we  = 1'b1;
        state_d = (cur_fill == '0) ? S_PUSH : S_SCAN;
      end
      S_SCAN: begin
        raddr = mem_addr(lvl_q, scan_slot);
        if (issue_q == cur_fill && !pend_q) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (lvl_q + 2'd1 >= levels_q || last_push_q[lvl_q] == '0 ||
            push_diff[31] || push_diff < gap_of(lvl_q)) begin
          state_d = S_FINAL;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_FINAL: begin
        div_req.start    = 1'b1;
        div_req.dividend = sum_q[fidx_q];
        div_req.divisor  = fill_q[fidx_q];
        state_d          = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_push_q)            state_d = S_COUNT;
          else if (fidx_q == LVL_DAY) state_d = S_RD_MIN;
          else                        state_d = S_FINAL;
        end
      end
      S_RD_MIN: begin
        raddr   = mem_addr(LVL_MIN, min_slot_q[LVL_MIN]);
        state_d = S_RD_MAX;
      end
      S_RD_MAX: begin
        raddr   = mem_addr(LVL_MIN, max_slot_q[LVL_MIN]);
        state_d = S_GET_MAX;
      end
      S_GET_MAX: state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign hour_live = (levels_q >= LVL_DAY) && (cnt_q[LVL_HOUR] != '0);
  assign avg_hour  = hour_live ? avg_q[LVL_HOUR] : avg_q[LVL_MIN];
  assign avg_day   = !hour_live ? avg_q[LVL_MIN] :
                     ((levels_q == 2'd3 && cnt_q[LVL_DAY] != '0) ? avg_q[LVL_DAY]
                                                                 : avg_q[LVL_HOUR]);

  // control state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      level_count_q <= 2'd1;
      out_valid_q   <= 1'b0;
      pend_q        <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i]       <= '0;
        head_q[i]      <= '0;
        fill_q[i]      <= '0;
        min_slot_q[i]  <= '0;
        max_slot_q[i]  <= '0;
        last_push_q[i] <= '0;
        cnt_q[i]       <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) level_count_q <= cfg_wdata_i;
      // raise the result once the output register is free, drop it once taken
      if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            v_q      <= $signed(s_axis_tdata[31:0]);
            v0_q     <= $signed(s_axis_tdata[31:0]);
            t_q      <= s_axis_tdata[63:32];
            lvl_q    <= LVL_MIN;
            levels_q <= (level_count_q == 2'd0) ? 2'd1 : level_count_q;
          end
        end
        S_COUNT: begin
          if (cnt_q[lvl_q] != '1) cnt_q[lvl_q] <= cnt_q[lvl_q] + 32'd1;
          oldest_q <= t_q - window_of(lvl_q);
        end
        S_EV_RD: ;
        S_EV_CHK, S_FULL_EV: begin
          // drop the oldest entry
          if (state_q == S_FULL_EV || rd_time < oldest_q) begin
            sum_q[lvl_q]  <= sum_q[lvl_q] - SUM_W'(rd_val);
            head_q[lvl_q] <= wrap_add(cur_head, FILL_W'(1), cur_depth);
            fill_q[lvl_q] <= cur_fill - FILL_W'(1);
          end
        end
        S_FULL_RD: ;
        S_WRITE: begin
          fill_q[lvl_q] <= cur_fill + FILL_W'(1);
          sum_q[lvl_q]  <= sum_q[lvl_q] + SUM_W'(v_q);
          if (cur_fill == '0) begin
            min_slot_q[lvl_q] <= new_slot;
            max_slot_q[lvl_q] <= new_slot;
          end
          issue_q <= '0;
          pend_q  <= 1'b0;
          first_q <= 1'b1;
        end
        S_SCAN: begin
          // issue one read per cycle, compare the data of the previous one
          if (issue_q != cur_fill) begin
            issue_q     <= issue_q + FILL_W'(1);
            pend_q      <= 1'b1;
            pend_slot_q <= scan_slot;
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q) begin
            first_q <= 1'b0;
            if (first_q || rd_val >= bmax_v_q) begin
              bmax_v_q <= rd_val;
              bmax_s_q <= pend_slot_q;
            end
            if (first_q || rd_val <= bmin_v_q) begin
              bmin_v_q <= rd_val;
              bmin_s_q <= pend_slot_q;
            end
          end
          if (issue_q == cur_fill && !pend_q) begin
            max_slot_q[lvl_q] <= bmax_s_q;
            min_slot_q[lvl_q] <= bmin_s_q;
          end
        end
        S_PUSH: begin
          fidx_q     <= LVL_MIN;
          div_push_q <= (lvl_q + 2'd1 < levels_q) && (last_push_q[lvl_q] != '0) &&
                        !push_diff[31] && (push_diff >= gap_of(lvl_q));
          if (lvl_q + 2'd1 < levels_q) begin
            if (last_push_q[lvl_q] == '0) begin
              last_push_q[lvl_q] <= t_q - 32'd1;
            end else if (!push_diff[31] && push_diff >= gap_of(lvl_q)) begin
              last_push_q[lvl_q] <= t_q;
            end
          end
        end
        S_FINAL: ;
        S_DIV: begin
          if (div_rsp.done) begin
            if (div_push_q) begin
              v_q        <= $signed(div_rsp.quotient);
              lvl_q      <= lvl_q + 2'd1;
              div_push_q <= 1'b0;
            end else begin
              avg_q[fidx_q] <= $signed(div_rsp.quotient);
              if (fidx_q != LVL_DAY) fidx_q <= fidx_q + 2'd1;
            end
          end
        end
        S_RD_MIN: ;
        S_RD_MAX: min_val_q <= rd_val;
        S_GET_MAX: max_val_q <= rd_val;
        S_OUT: begin
          // load the result once the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_data_q[31:0]     <= v0_q;
            out_data_q[63:32]    <= min_val_q;
            out_data_q[95:64]    <= max_val_q;
            out_data_q[127:96]   <= avg_q[LVL_MIN];
            out_data_q[159:128]  <= avg_hour;
            out_data_q[191:160]  <= avg_day;
            out_data_q[223:192]  <= cnt_q[LVL_MIN];
          end
        end
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `CTWA_ASSERT(a_min_fill, fill_q[LVL_MIN] <= FILL_W'(SHORT_DEPTH), "minute fill overflow")
  `CTWA_ASSERT(a_day_fill, fill_q[LVL_DAY] <= FILL_W'(DAY_DEPTH), "day fill overflow")
  `CTWA_ASSERT_IMP(a_min_max, m_axis_tvalid,
    $signed(m_axis_tdata[63:32]) <= $signed(m_axis_tdata[95:64]), "min above max")
  `CTWA_ASSERT_IMP(a_div_done, div_rsp.done, state_q == S_DIV, "stray divider result")
  `CTWA_ASSERT_IMP(a_total, m_axis_tvalid, m_axis_tdata[223:192] != 32'd0, "zero total")

endmodule
